>>> rtl/assert_macros.svh
// Assertion macros shared by the alpha bleed RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while in reset.
`define ABD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ABD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/abd_pkg.sv
// Shared types, constants and helpers of the alpha bleed dilation block.
// No dependencies.
package abd_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;
  localparam int unsigned DefMaxPasses = 4;

  // column/row fields wide enough for the largest supported frame
  localparam int unsigned PosW = 13;
  localparam int unsigned CfgW = 11;
  localparam int unsigned PassW = 3;

  localparam int unsigned ResetWidth  = 1024;
  localparam int unsigned ResetHeight = 1024;
  localparam int unsigned ResetPasses = 1;

  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegPassCount   = 2'd2;

  localparam logic OpPush  = 1'b0;
  localparam logic OpDrain = 1'b1;

  // window taps: centre first, then the eight neighbours
  localparam int unsigned NbCount = 9;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } abd_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } abd_out_t;

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic            opaque;
    logic            last;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
  } abd_pix_t;

  // one hop along the chain of stages
  typedef struct packed {
    logic     go;
    logic     have;
    abd_pix_t pix;
  } abd_tok_t;

  typedef enum logic [1:0] {
    CellIdle,
    CellRead,
    CellResolve
  } abd_cell_state_e;

  function automatic logic signed [1:0] nb_dy(input logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd1, 4'd2, 4'd3: d = -2'sd1;
      4'd6, 4'd7, 4'd8: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dx(input logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd1, 4'd4, 4'd6: d = -2'sd1;
      4'd3, 4'd5, 4'd8: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  // floor(sum / cnt) for cnt 1..8 and sum up to 8*255, by rounded-up reciprocal
  function automatic logic [7:0] mean_div(input logic [10:0] sum, input logic [3:0] cnt);
    logic [16:0] recip;
    logic [27:0] prod;
    case (cnt)
      4'd1:    recip = 17'd65536;
      4'd2:    recip = 17'd32768;
      4'd3:    recip = 17'd21846;
      4'd4:    recip = 17'd16384;
      4'd5:    recip = 17'd13108;
      4'd6:    recip = 17'd10923;
      4'd7:    recip = 17'd9363;
      4'd8:    recip = 17'd8192;
      default: recip = 17'd0;
    endcase
    prod = {17'b0, sum} * {11'b0, recip};
    return prod[23:16];
  endfunction

endpackage

>>> rtl/abd_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module abd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/abd_cell.sv
// One bleed stage of the chain: ring of cells, 3x3 window read, mean.
// Depends on abd_pkg, abd_ram and assert_macros.svh.
`include "assert_macros.svh"

module abd_cell #(
  parameter int unsigned MaxWidth  = abd_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = abd_pkg::DefMaxHeight
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           active_i,
  input  logic [$clog2(MaxWidth+1)-1:0]  width_i,
  input  logic [$clog2(MaxHeight+1)-1:0] height_i,
  input  abd_pkg::abd_tok_t              tok_i,
  output abd_pkg::abd_tok_t              tok_o
);

  localparam int unsigned Ring = 2 * MaxWidth + 3;
  localparam int unsigned AW   = $clog2(Ring);
  localparam int unsigned FW   = $clog2(Ring + 1);
  localparam int unsigned TW   = AW + 2;
  localparam int unsigned XW   = abd_pkg::PosW + 1;

  abd_pkg::abd_cell_state_e state_q, state_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [FW-1:0]      fill_q, fill_d, ends_q, ends_d;
  logic [FW-1:0]      fill_new, ends_new;
  logic [3:0]         k_q, k_d, j;
  logic [10:0]        sum_r_q, sum_r_d, sum_g_q, sum_g_d, sum_b_q, sum_b_d;
  logic [3:0]         cnt_q, cnt_d;
  abd_pkg::abd_pix_t  ctr_q, ctr_d, rdata, res;
  abd_pkg::abd_tok_t  tok_q, tok_d;

  logic               wr_en, rd_en, emit;
  logic [AW:0]        slot_sum;
  logic [AW-1:0]      slot, rd_addr;
  logic signed [1:0]  dy, dx, dyj, dxj;
  logic signed [TW-1:0] t, wofs;
  logic               x_ok, y_ok;
  logic [XW-1:0]      wx, hx, colx, rowx;

  // ring write for an incoming pixel
  assign wr_en = (state_q == abd_pkg::CellIdle) && tok_i.go && active_i && tok_i.have &&
                 (fill_q < FW'(Ring));
  assign slot_sum = (AW+1)'(pos_q) + (AW+1)'(fill_q);
  assign slot = (slot_sum >= (AW+1)'(Ring)) ? AW'(slot_sum - (AW+1)'(Ring)) : AW'(slot_sum);
  assign fill_new = fill_q + FW'(wr_en);
  assign ends_new = ends_q + FW'(wr_en && tok_i.pix.last);
  assign emit = (fill_new != '0) &&
                ((32'(fill_new) > 32'(width_i) + 32'd1) || (ends_new != '0));

  // window tap address around the head
  assign dy = abd_pkg::nb_dy(k_q);
  assign dx = abd_pkg::nb_dx(k_q);
  always_comb begin
    if (dy == 2'sd1) begin
      wofs = $signed(TW'(width_i));
    end else if (dy == -2'sd1) begin
      wofs = -$signed(TW'(width_i));
    end else begin
      wofs = '0;
    end
    t = $signed(TW'(pos_q)) + wofs + TW'(dx);
    if (t < 0) begin
      rd_addr = AW'(t + $signed(TW'(Ring)));
    end else if (t >= $signed(TW'(Ring))) begin
      rd_addr = AW'(t - $signed(TW'(Ring)));
    end else begin
      rd_addr = AW'(t);
    end
  end

  abd_ram #(
    .Width ($bits(abd_pkg::abd_pix_t)),
    .Depth (Ring)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot),
    .wdata_i (tok_i.pix),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // in-frame test of the tap whose data arrives now
  assign j    = k_q - 4'd1;
  assign dyj  = abd_pkg::nb_dy(j);
  assign dxj  = abd_pkg::nb_dx(j);
  assign wx   = XW'(width_i);
  assign hx   = XW'(height_i);
  assign colx = XW'(ctr_q.col);
  assign rowx = XW'(ctr_q.row);

  // a centre left over from a wider frame may sit beyond the edge
  always_comb begin
    if (dxj == -2'sd1) begin
      x_ok = (colx != '0) && (colx <= wx);
    end else if (dxj == 2'sd1) begin
      x_ok = (colx + XW'(1)) < wx;
    end else begin
      x_ok = colx < wx;
    end
    if (dyj == -2'sd1) begin
      y_ok = (rowx != '0) && (rowx <= hx);
    end else if (dyj == 2'sd1) begin
      y_ok = (rowx + XW'(1)) < hx;
    end else begin
      y_ok = rowx < hx;
    end
  end

  always_comb begin
    res = ctr_q;
    if (!ctr_q.opaque && (cnt_q != '0)) begin
      res.red    = abd_pkg::mean_div(sum_r_q, cnt_q);
      res.green  = abd_pkg::mean_div(sum_g_q, cnt_q);
      res.blue   = abd_pkg::mean_div(sum_b_q, cnt_q);
      res.opaque = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      abd_pkg::CellIdle: begin
        if (tok_i.go && active_i && emit) begin
          state_d = abd_pkg::CellRead;
        end
      end
      abd_pkg::CellRead: begin
        if (k_q == 4'(abd_pkg::NbCount)) begin
          state_d = abd_pkg::CellResolve;
        end
      end
      abd_pkg::CellResolve: state_d = abd_pkg::CellIdle;
      default: state_d = abd_pkg::CellIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pos_d   = pos_q;
    fill_d  = fill_q;
    ends_d  = ends_q;
    k_d     = k_q;
    sum_r_d = sum_r_q;
    sum_g_d = sum_g_q;
    sum_b_d = sum_b_q;
    cnt_d   = cnt_q;
    ctr_d   = ctr_q;
    tok_d   = tok_q;
    tok_d.go = 1'b0;
    rd_en   = 1'b0;
    unique case (state_q)
      abd_pkg::CellIdle: begin
        if (tok_i.go) begin
          if (!active_i) begin
            tok_d = tok_i;
          end else begin
            fill_d  = fill_new;
            ends_d  = ends_new;
            k_d     = '0;
            sum_r_d = '0;
            sum_g_d = '0;
            sum_b_d = '0;
            cnt_d   = '0;
            if (!emit) begin
              tok_d.go   = 1'b1;
              tok_d.have = 1'b0;
              tok_d.pix  = tok_i.pix;
            end
          end
        end
      end
      abd_pkg::CellRead: begin
        rd_en = k_q < 4'(abd_pkg::NbCount);
        k_d   = k_q + 4'd1;
        if (k_q == 4'd1) begin
          ctr_d = rdata;
        end else if (k_q != '0) begin
          if (x_ok && y_ok && rdata.opaque) begin
            sum_r_d = sum_r_q + 11'(rdata.red);
            sum_g_d = sum_g_q + 11'(rdata.green);
            sum_b_d = sum_b_q + 11'(rdata.blue);
            cnt_d   = cnt_q + 4'd1;
          end
        end
      end
      abd_pkg::CellResolve: begin
        tok_d.go   = 1'b1;
        tok_d.have = 1'b1;
        tok_d.pix  = res;
        pos_d  = (pos_q == AW'(Ring - 1)) ? '0 : pos_q + AW'(1);
        fill_d = fill_q - FW'(1);
        if (ctr_q.last && (ends_q != '0)) begin
          ends_d = ends_q - FW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abd_pkg::CellIdle;
      pos_q   <= '0;
      fill_q  <= '0;
      ends_q  <= '0;
      k_q     <= '0;
      tok_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      ends_q  <= ends_d;
      k_q     <= k_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_r_q <= sum_r_d;
    sum_g_q <= sum_g_d;
    sum_b_q <= sum_b_d;
    cnt_q   <= cnt_d;
    ctr_q   <= ctr_d;
  end

  assign tok_o = tok_q;

  `ABD_ASSERT(a_fill_bound, fill_q <= FW'(Ring), "ring fill beyond depth")
  `ABD_ASSERT(a_ends_bound, ends_q <= fill_q, "more frame ends than pending cells")
  `ABD_ASSERT(a_busy_no_go, (state_q != abd_pkg::CellIdle) |-> !tok_i.go, "beat while busy")

endmodule

>>> rtl/alpha_bleed_dilation.sv
// Streaming alpha bleed: RGBA pixels arrive in raster order on the input
// channel (operation push) and leave, after up to pass_count 3x3 bleed
// passes, with their original alpha and a frame_end flag on the frame's last
// pixel. Each pass delays the stream by frame_width+1 pixels, so after the
// last pixel of a frame the tail is pushed out by drain beats (or by the next
// frame's pixels). One beat is handled at a time: each pass in use writes
// its ring once and then reads it nine times for the window, then forms
// the mean in a resolve state. A finished pixel waits in the output
// register, so the next beat is taken while it is still pending. Ring stores
// need no clearing pass after reset. Registers sit at byte offsets 0
// (frame_width), 4 (frame_height) and 8 (pass_count); write them only while
// the block is idle.
// Depends on abd_pkg, abd_cell, abd_ram and assert_macros.svh.
`include "assert_macros.svh"

module alpha_bleed_dilation #(
  parameter int unsigned MaxWidth  = abd_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = abd_pkg::DefMaxHeight,
  parameter int unsigned MaxPasses = abd_pkg::DefMaxPasses
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  abd_pkg::abd_in_t  in_data_i,
  // pixel output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output abd_pkg::abd_out_t out_data_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned WW   = $clog2(MaxWidth + 1);
  localparam int unsigned HW   = $clog2(MaxHeight + 1);
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;

  // configuration registers
  logic [abd_pkg::CfgW-1:0]  fw_q, fw_d, fh_q, fh_d;
  logic [abd_pkg::PassW-1:0] pc_q, pc_d;
  logic                      cfg_we;

  // effective sizes after clamping
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [31:0]    p_eff;

  // input position counters
  logic [ColW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic            col_wrap, row_wrap;

  logic                  in_acc, busy_q, busy_d;
  logic                  res_valid_q, res_valid_d, out_valid_q, out_valid_d, out_load;
  abd_pkg::abd_pix_t     res_q, res_d;
  abd_pkg::abd_out_t     out_q, out_d;
  abd_pkg::abd_tok_t     tok [MaxPasses+1];
  logic [MaxPasses-1:0]  active;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    pc_d = pc_q;
    if (cfg_we) begin
      unique case (paddr[3:2])
        abd_pkg::RegFrameWidth:  fw_d = pwdata[abd_pkg::CfgW-1:0];
        abd_pkg::RegFrameHeight: fh_d = pwdata[abd_pkg::CfgW-1:0];
        abd_pkg::RegPassCount:   pc_d = pwdata[abd_pkg::PassW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      abd_pkg::RegFrameWidth:  prdata = 32'(fw_q);
      abd_pkg::RegFrameHeight: prdata = 32'(fh_q);
      abd_pkg::RegPassCount:   prdata = 32'(pc_q);
      default:                 prdata = '0;
    endcase
  end

  // zero counts as one, oversize saturates
  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_q) > MaxWidth) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(fh_q) > MaxHeight) begin
      h_eff = HW'(MaxHeight);
    end else begin
      h_eff = HW'(fh_q);
    end
    p_eff = (32'(pc_q) > MaxPasses) ? MaxPasses : 32'(pc_q);
  end

  // raster position of the next pushed pixel
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign col_wrap   = 32'(in_col_q) + 32'd1 >= 32'(w_eff);
  assign row_wrap   = 32'(in_row_q) + 32'd1 >= 32'(h_eff);

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (in_acc && (in_data_i.operation == abd_pkg::OpPush)) begin
      if (col_wrap) begin
        in_col_d = '0;
        in_row_d = row_wrap ? '0 : in_row_q + RowW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
    end
  end

  always_comb begin
    tok[0].go         = in_acc;
    tok[0].have       = in_data_i.operation == abd_pkg::OpPush;
    tok[0].pix.red    = in_data_i.in_red;
    tok[0].pix.green  = in_data_i.in_green;
    tok[0].pix.blue   = in_data_i.in_blue;
    tok[0].pix.alpha  = in_data_i.in_alpha;
    tok[0].pix.opaque = in_data_i.in_alpha != '0;
    tok[0].pix.last   = col_wrap && row_wrap;
    tok[0].pix.col    = abd_pkg::PosW'(in_col_q);
    tok[0].pix.row    = abd_pkg::PosW'(in_row_q);
  end

  // chain of bleed stages; stages beyond pass_count hand the beat on untouched
  for (genvar i = 0; i < MaxPasses; i++) begin : g_stage
    assign active[i] = 32'(i) < p_eff;
    abd_cell #(
      .MaxWidth  (MaxWidth),
      .MaxHeight (MaxHeight)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active[i]),
      .width_i  (w_eff),
      .height_i (h_eff),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  // result holding stage, then the output register
  assign out_load = res_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    busy_d      = busy_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d         = 1'b1;
      out_d.out_red       = res_q.red;
      out_d.out_green     = res_q.green;
      out_d.out_blue      = res_q.blue;
      out_d.out_alpha     = res_q.alpha;
      out_d.frame_end     = res_q.last;
      res_valid_d         = 1'b0;
      busy_d              = 1'b0;
    end
    if (tok[MaxPasses].go) begin
      if (tok[MaxPasses].have) begin
        res_valid_d = 1'b1;
        res_d       = tok[MaxPasses].pix;
      end else begin
        busy_d = 1'b0;
      end
    end
    if (in_acc) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= abd_pkg::CfgW'(abd_pkg::ResetWidth);
      fh_q        <= abd_pkg::CfgW'(abd_pkg::ResetHeight);
      pc_q        <= abd_pkg::PassW'(abd_pkg::ResetPasses);
      in_col_q    <= '0;
      in_row_q    <= '0;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fw_q        <= fw_d;
      fh_q        <= fh_d;
      pc_q        <= pc_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ABD_ASSERT(a_accept_busy, (in_valid_i && in_ready_o) |=> busy_q, "accepted beat not tracked")
  `ABD_ASSERT(a_res_busy, res_valid_q |-> busy_q, "held result without a beat in flight")
  `ABD_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)), "output beat dropped or changed while stalled")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for alpha_bleed_dilation: streams RGBA beats,
// predicts each bled pixel and compares every output beat field by field.
// Depends on abd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MaxW      = abd_pkg::DefMaxWidth;
  localparam int unsigned MaxH      = abd_pkg::DefMaxHeight;
  localparam int unsigned MaxP      = abd_pkg::DefMaxPasses;
  localparam int unsigned RingDepth = 2 * MaxW + 3;
  localparam int unsigned Settle    = 120;
  localparam int unsigned CycleCap  = 1000000;
  localparam int unsigned WideW     = 32;
  localparam int unsigned ItemGoal  = 740;

  localparam logic [3:0] AddrWidth  = 4'd4 * abd_pkg::RegFrameWidth;
  localparam logic [3:0] AddrHeight = 4'd4 * abd_pkg::RegFrameHeight;
  localparam logic [3:0] AddrPasses = 4'd4 * abd_pkg::RegPassCount;
  localparam logic [3:0] AddrSpare  = 4'd12;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  abd_pkg::abd_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  abd_pkg::abd_out_t out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [3:0]        paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  alpha_bleed_dilation DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------
  // Predictor: a copy of every stage's ring, its head, fill and the
  // number of pending frame ends, plus the input raster counters.
  // ---------------------------------------------------------------
  typedef struct {
    logic [7:0]  red, green, blue, alpha;
    bit          opaque, last;
    int unsigned col, row;
  } px_t;

  px_t         ring_q [MaxP][RingDepth];
  int unsigned ring_head [MaxP];
  int unsigned ring_fill [MaxP];
  int unsigned ring_ends [MaxP];
  int unsigned cfg_width  = 1024;
  int unsigned cfg_height = 1024;
  int unsigned cfg_passes = 1;
  int unsigned raster_col = 0;
  int unsigned raster_row = 0;

  abd_pkg::abd_out_t pending_px [$];   // bled pixels still owed by the block
  int unsigned mismatches = 0;
  int unsigned rx_hold    = 0;   // long receiver hold-off, in cycles
  int unsigned cycles     = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // 3x3 bleed of the oldest pending pixel of stage s
  function automatic px_t bleed_px(int unsigned s, int unsigned w, int unsigned h);
    px_t         c;
    px_t         nb;
    int unsigned sr, sg, sb, n, idx;
    int          nx, ny, off;
    c  = ring_q[s][ring_head[s]];
    sr = 0; sg = 0; sb = 0; n = 0;
    if (c.opaque) return c;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = int'(c.col) + dx;
        ny = int'(c.row) + dy;
        if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h))
          continue;
        off = dy * int'(w) + dx + int'(w) + 1;
        idx = (ring_head[s] + RingDepth - (w + 1) + off) % RingDepth;
        nb  = ring_q[s][idx];
        if (!nb.opaque) continue;
        sr += nb.red; sg += nb.green; sb += nb.blue; n++;
      end
    end
    if (n > 0) begin
      c.red    = 8'(sr / n);
      c.green  = 8'(sg / n);
      c.blue   = 8'(sb / n);
      c.opaque = 1'b1;
    end
    return c;
  endfunction

  // advance the predictor by one accepted beat, queue any bled pixel
  function automatic void predict_beat(abd_pkg::abd_in_t b);
    int unsigned       w, h, p, slot;
    px_t               cur;
    bit                have;
    abd_pkg::abd_out_t o;
    w    = clamp_dim(cfg_width, MaxW);
    h    = clamp_dim(cfg_height, MaxH);
    p    = (cfg_passes > MaxP) ? MaxP : cfg_passes;
    cur  = '{default: 0};
    have = 1'b0;
    if (b.operation == abd_pkg::OpPush) begin
      cur.red    = b.in_red;
      cur.green  = b.in_green;
      cur.blue   = b.in_blue;
      cur.alpha  = b.in_alpha;
      cur.opaque = (b.in_alpha != 0);
      cur.col    = raster_col;
      cur.row    = raster_row;
      cur.last   = (raster_col + 1 >= w) && (raster_row + 1 >= h);
      have       = 1'b1;
      if (raster_col + 1 >= w) begin
        raster_col = 0;
        raster_row = (raster_row + 1 >= h) ? 0 : raster_row + 1;
      end else begin
        raster_col++;
      end
    end
    for (int unsigned s = 0; s < p; s++) begin
      if (have && ring_fill[s] < RingDepth) begin
        slot = (ring_head[s] + ring_fill[s]) % RingDepth;
        ring_q[s][slot] = cur;
        ring_fill[s]++;
        if (cur.last) ring_ends[s]++;
      end
      have = 1'b0;
      if (ring_fill[s] > 0 && (ring_fill[s] > w + 1 || ring_ends[s] > 0)) begin
        cur = bleed_px(s, w, h);
        ring_head[s] = (ring_head[s] + 1) % RingDepth;
        ring_fill[s]--;
        if (cur.last && ring_ends[s] > 0) ring_ends[s]--;
        have = 1'b1;
      end
    end
    if (have) begin
      o.out_red   = cur.red;
      o.out_green = cur.green;
      o.out_blue  = cur.blue;
      o.out_alpha = cur.alpha;
      o.frame_end = cur.last;
      pending_px.push_back(o);
    end
  endfunction

  initial begin
    for (int s = 0; s < MaxP; s++) begin
      ring_head[s] = 0; ring_fill[s] = 0; ring_ends[s] = 0;
      for (int i = 0; i < RingDepth; i++) ring_q[s][i] = '{default: 0};
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------
  // Receiver: random back-pressure plus the long hold-off; checks each
  // output beat against the oldest owed pixel.
  // ---------------------------------------------------------------
  int unsigned rx_stall = 0;
  always @(posedge clk_i) begin
    abd_pkg::abd_out_t want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (pending_px.size() == 0) begin
          report_mismatch("unexpected output beat", 1, 0);
        end else begin
          want = pending_px.pop_front();
          if (out_data_o.out_red != want.out_red)
            report_mismatch("out_red", out_data_o.out_red, want.out_red);
          if (out_data_o.out_green != want.out_green)
            report_mismatch("out_green", out_data_o.out_green, want.out_green);
          if (out_data_o.out_blue != want.out_blue)
            report_mismatch("out_blue", out_data_o.out_blue, want.out_blue);
          if (out_data_o.out_alpha != want.out_alpha)
            report_mismatch("out_alpha", out_data_o.out_alpha, want.out_alpha);
          if (out_data_o.frame_end != want.frame_end)
            report_mismatch("frame_end", out_data_o.frame_end, want.frame_end);
        end
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_ready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall = rx_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 20) rx_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleCap) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------
  int unsigned beats_sent = 0;

  // one beat; called and returning at a rising edge
  task automatic send_beat(abd_pkg::abd_in_t b, int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_beat(b);
    beats_sent++;
  endtask

  function automatic abd_pkg::abd_in_t make_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [7:0] a);
    abd_pkg::abd_in_t x;
    x.operation = abd_pkg::OpPush;
    x.in_red = r; x.in_green = g; x.in_blue = b; x.in_alpha = a;
    return x;
  endfunction

  function automatic abd_pkg::abd_in_t rand_px(int unsigned clear_pct);
    abd_pkg::abd_in_t x;
    x = make_px(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 99) < clear_pct) x.in_alpha = 8'd0;
    return x;
  endfunction

  // drain beat with random colour bits, which the block ignores
  function automatic abd_pkg::abd_in_t drain_beat();
    abd_pkg::abd_in_t x;
    x = rand_px(0);
    x.operation = abd_pkg::OpDrain;
    return x;
  endfunction

  // wait until every owed pixel is out, then let the block settle
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      AddrWidth:  cfg_width  = data & 32'h7FF;
      AddrHeight: cfg_height = data & 32'h7FF;
      AddrPasses: cfg_passes = data & 32'h7;
      default: ;
    endcase
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned p);
    reg_write(AddrWidth, w);
    reg_write(AddrHeight, h);
    reg_write(AddrPasses, p);
  endtask

  task automatic drain_n(int unsigned n, bit gaps);
    repeat (n) send_beat(drain_beat(), gaps ? pick_gap() : 0);
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // Oversize values saturate to the maxima; a few pixels sit in the rings
  // without any output, then a small frame pushes them out.
  task automatic test_oversize();
    set_frame(2047, 2047, 7);
    repeat (6) send_beat(rand_px(50), pick_gap());
    wait_quiet();
    set_frame(3, 2, 4);
    repeat (6) send_beat(rand_px(50), 0);
    drain_n(4 * 4 + 2, 1'b0);
    wait_quiet();
  endtask

  // Extremes of colour and alpha, early drains, draining an empty block.
  task automatic test_extremes();
    set_frame(3, 2, 1);
    send_beat(drain_beat(), 0);                  // nothing pending
    send_beat(make_px(8'hFF, 8'hFF, 8'hFF, 8'hFF), 0);
    send_beat(make_px(8'h00, 8'h00, 8'h00, 8'h00), 0);
    send_beat(drain_beat(), 0);                  // drain before frame end
    send_beat(make_px(8'hFF, 8'h00, 8'hFF, 8'h01), 0);
    send_beat(make_px(8'h00, 8'hFF, 8'h00, 8'h00), 1);
    send_beat(make_px(8'h80, 8'h7F, 8'h01, 8'h00), 0);
    send_beat(make_px(8'h00, 8'h00, 8'h00, 8'hFF), 0);
    drain_n(6, 1'b0);
    send_beat(drain_beat(), 0);                  // everything already out
    wait_quiet();
  endtask

  // Zero sizes count as one; zero passes sends pixels straight through;
  // a write beyond the last register changes nothing.
  task automatic test_sizes_and_bypass();
    set_frame(0, 0, 2);
    repeat (3) send_beat(rand_px(50), 0);
    drain_n(3, 1'b0);
    wait_quiet();
    set_frame(4, 3, 0);
    reg_write(AddrSpare, 32'hFFFF_FFFF);
    repeat (4) send_beat(rand_px(50), pick_gap());
    send_beat(drain_beat(), 0);
    wait_quiet();
  endtask

  // Next frame pushed straight in, without drains, across several passes.
  task automatic test_back_to_back();
    set_frame(2, 2, 3);
    repeat (12) send_beat(rand_px(60), 0);
    drain_n(3 * 3 + 1, 1'b0);
    wait_quiet();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // beats, so the block fills up and stalls its input.
  task automatic test_backpressure();
    set_frame(4, 3, 2);
    @(posedge clk_i);
    rx_hold = 600;
    repeat (24) send_beat(rand_px(50), 0);
    drain_n(2 * 5, 1'b0);
    wait_quiet();
  endtask

  // Random frames, mostly small: random pass counts, mostly well-formed frames,
  // some early drains, then flushing drains or at times a random number.
  task automatic test_random_frames();
    int unsigned w, h, p, n_px, n_drain;
    while (beats_sent < ItemGoal) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      p = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) w = WideW;
      if (w == WideW) h = 2;
      set_frame(w, h, p);
      repeat ($urandom_range(1, 3)) begin
        n_px = w * h;
        for (int unsigned i = 0; i < n_px; i++) begin
          if ($urandom_range(0, 99) < 4) send_beat(drain_beat(), pick_gap());
          send_beat(rand_px($urandom_range(20, 90)), pick_gap());
        end
      end
      // the widest frames are drained in one burst without gaps
      n_drain = p * (w + 1) + 1;
      if (w != WideW && $urandom_range(0, 3) == 0) n_drain = $urandom_range(0, n_drain);
      drain_n(n_drain, w != WideW);
      wait_quiet();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_oversize();
    test_extremes();
    test_sizes_and_bypass();
    test_back_to_back();
    test_backpressure();
    test_random_frames();
    wait_quiet();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/abd_pkg.sv
rtl/abd_ram.sv
rtl/abd_cell.sv
rtl/alpha_bleed_dilation.sv
dv/tb_top.sv
